/* rtl/sfdt_pkg.sv */
// Package for the save flush dirty timer: operation codes, medium codes,
// register indexes and the tracker state type. Used by the top level and its checker.
package sfdt_pkg;

	localparam int CntW = 8;
	localparam int StatusW = 24;
	localparam int CountW = 32;
	localparam int AddrW = 4;
	localparam int DataW = 32;

	localparam logic [CountW-1:0] SAT_MAX = '1;

	// Operation codes; code 3 has no meaning and is ignored
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_FLUSH = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	// Save medium codes, in rising priority
	typedef enum logic [1:0] {
		MED_NONE   = 2'd0,
		MED_SRAM   = 2'd1,
		MED_FLASH  = 2'd2,
		MED_EEPROM = 2'd3
	} medium_t;

	// Register word indexes (byte address 4*index)
	localparam logic [1:0] REG_QUIET_THR = 2'd0;
	localparam logic [1:0] REG_HARD_THR  = 2'd1;
	localparam logic [1:0] REG_LOADED    = 2'd2;

	typedef struct packed {
		logic [StatusW-1:0] seen;
		logic               dirty;
		medium_t            active;
		logic [CountW-1:0]  quiet;
		logic [CountW-1:0]  age;
		logic [CountW-1:0]  total;
	} track_t;

	// Saturating increment of a count
	function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
		sat_inc = (v == SAT_MAX) ? v : v + CountW'(1);
	endfunction

endpackage

/* rtl/save_flush_dirty_timer.sv */
// Top level of the save flush dirty timer: register port, input stage,
// tracker update and result register. Depends on sfdt_pkg.
// An accepted transaction passes the input stage, then the result register.
// Throughput: one transaction per cycle unless out_ready stalls the output;
// the tracker state is read and written in the single update stage, so each
// item sees the state left by the one before.
// Reset: arst_n clears the registers, the tracker state and both valid flags.
module save_flush_dirty_timer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sfdt_pkg::AddrW-1:0]    paddr,
	input  logic [sfdt_pkg::DataW-1:0]    pwdata,
	output logic [sfdt_pkg::DataW-1:0]    prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    operation,
	input  logic [sfdt_pkg::StatusW-1:0]  status_word,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          flush_request,
	output logic [1:0]                    flush_medium,
	output logic                          dirty_now,
	output logic [sfdt_pkg::CountW-1:0]   flushes_done
);
	import sfdt_pkg::*;

	logic [CountW-1:0]  quiet_thr_q;
	logic [CountW-1:0]  hard_thr_q;
	logic               loaded_q;

	logic               valid_s1;
	logic [1:0]         op_s1;
	logic [StatusW-1:0] status_s1;

	track_t             trk_q;
	track_t             trk_nxt;
	logic               req_nxt;
	medium_t            med_nxt;

	logic               advance;
	logic               wr_en;

	// Tick work signals
	medium_t            kind;
	logic               chg;
	logic               dirty_t;
	medium_t            medium_t_sel;
	logic [CountW-1:0]  quiet_inc;
	logic [CountW-1:0]  age_inc;
	logic               fire;

	// Register port
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_thr_q <= '0;
			hard_thr_q  <= '0;
			loaded_q    <= 1'b0;
		end else if (wr_en) begin
			case (paddr[AddrW-1:2])
				REG_QUIET_THR: quiet_thr_q <= pwdata;
				REG_HARD_THR:  hard_thr_q  <= pwdata;
				REG_LOADED:    loaded_q    <= pwdata[0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		case (paddr[AddrW-1:2])
			REG_QUIET_THR: prdata = quiet_thr_q;
			REG_HARD_THR:  prdata = hard_thr_q;
			REG_LOADED:    prdata = {{(DataW-1){1'b0}}, loaded_q};
			default:       prdata = '0;
		endcase
	end

	// Handshake: the update stage moves when the result register is free
	assign advance  = !out_valid || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (advance)  out_valid <= valid_s1;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1     <= operation;
			status_s1 <= status_word;
		end
	end

	// Highest priority medium whose counter moved
	always_comb begin
		if (status_s1[23:16] != trk_q.seen[23:16])     kind = MED_EEPROM;
		else if (status_s1[15:8] != trk_q.seen[15:8])  kind = MED_FLASH;
		else if (status_s1[7:0] != trk_q.seen[7:0])    kind = MED_SRAM;
		else                                           kind = MED_NONE;
	end

	// Tick: zero quiet on change, age on new dirty medium; count, test
	always_comb begin
		chg          = (kind != MED_NONE);
		dirty_t      = trk_q.dirty || chg;
		medium_t_sel = chg ? kind : trk_q.active;
		quiet_inc    = sat_inc(chg ? '0 : trk_q.quiet);
		age_inc      = sat_inc((chg && (!trk_q.dirty || trk_q.active != kind)) ?
			'0 : trk_q.age);
		fire         = dirty_t && (quiet_inc >= quiet_thr_q || age_inc >= hard_thr_q);
	end

	// Next tracker state and result
	always_comb begin
		trk_nxt = trk_q;
		req_nxt = 1'b0;
		med_nxt = MED_NONE;
		case (op_s1)
			OP_TICK: begin
				if (loaded_q) begin
					if (chg) trk_nxt.seen = status_s1;
					trk_nxt.active = medium_t_sel;
					if (fire) begin
						req_nxt       = 1'b1;
						med_nxt       = medium_t_sel;
						trk_nxt.dirty = 1'b0;
						trk_nxt.quiet = '0;
						trk_nxt.age   = '0;
						trk_nxt.total = trk_q.total + CountW'(1);
					end else if (dirty_t) begin
						trk_nxt.dirty = 1'b1;
						trk_nxt.quiet = quiet_inc;
						trk_nxt.age   = age_inc;
					end
				end
			end
			OP_FLUSH: begin
				if (loaded_q && trk_q.dirty) begin
					req_nxt       = 1'b1;
					med_nxt       = trk_q.active;
					trk_nxt.dirty = 1'b0;
					trk_nxt.quiet = '0;
					trk_nxt.age   = '0;
					trk_nxt.total = trk_q.total + CountW'(1);
				end
			end
			OP_CLEAR: begin
				trk_nxt = '0;
			end
			default: ;
		endcase
	end

	// Tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trk_q <= '0;
		end else if (valid_s1 && advance) begin
			trk_q <= trk_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			flush_request <= req_nxt;
			flush_medium  <= med_nxt;
			dirty_now     <= trk_nxt.dirty;
			flushes_done  <= trk_nxt.total;
		end
	end

endmodule

/* rtl/sfdt_checker.sv */
// Port checker for the save flush dirty timer and its bind to the top level.
// Depends on sfdt_pkg and save_flush_dirty_timer.
module sfdt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          flush_request,
	input logic [1:0]                    flush_medium,
	input logic                          dirty_now,
	input logic [sfdt_pkg::CountW-1:0]   flushes_done
);
	import sfdt_pkg::*;

	// A stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(flushes_done) &&
		$stable(flush_request) && $stable(flush_medium) && $stable(dirty_now))
		else $error("result changed while stalled");

	// A flush always leaves the medium clean
	a_flush_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && flush_request |-> !dirty_now)
		else $error("dirty after flush");

	// A flush names a real medium
	a_flush_medium: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && flush_request |-> flush_medium != MED_NONE)
		else $error("flush without medium");

	// No flush, no medium
	a_no_medium: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !flush_request |-> flush_medium == MED_NONE)
		else $error("medium without flush");

endmodule

bind save_flush_dirty_timer sfdt_checker u_sfdt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.flush_request (flush_request),
	.flush_medium  (flush_medium),
	.dirty_now     (dirty_now),
	.flushes_done  (flushes_done)
);
